// ===== sv/vtlf_pkg.sv =====
package vtlf_pkg;

    // default list geometry
    localparam int LIST_ENTRIES_DEF = 64;
    localparam int CORE_COUNT_DEF   = 4;

    // fixed field widths
    localparam int KIND_W = 2;
    localparam int CORE_W = 2;
    localparam int ADDR_W = 48;
    localparam int HIT_W  = 32;

    // request kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_FILL  = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

endpackage

// ===== sv/vtlf_tag_ram.sv =====
module vtlf_tag_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 48
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/victim_tag_lru_filter.sv =====
// channel | handshake         | fields                                                    | dir
// --------+-------------------+-----------------------------------------------------------+----
// s_      | s_valid s_ready   | s_req_type s_core_id s_phys_addr s_fill_mark_in s_cache_hit | in
// m_      | m_valid m_ready   | m_type_out m_fill_mark_out m_victim_hit m_hit_total       | out
//
// no search: the accept moves the transaction to the done step; m_valid and s_ready
//   rise together when the result loads into the free output register
// search: one list slot read per cycle through the tag ram read port, then a
//   write-back step; m_valid rises after the scan, write-back and done steps
// aresetn (synchronous) empties every list and clears the hit counter; tag ram not cleared
// s_ready is low while a transaction is in flight; a held result stalls only the done step

module victim_tag_lru_filter #(
    parameter int LIST_ENTRIES = vtlf_pkg::LIST_ENTRIES_DEF,
    parameter int CORE_COUNT   = vtlf_pkg::CORE_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [vtlf_pkg::KIND_W-1:0] s_req_type,
    input  logic [vtlf_pkg::CORE_W-1:0] s_core_id,
    input  logic [vtlf_pkg::ADDR_W-1:0] s_phys_addr,
    input  logic                        s_fill_mark_in,
    input  logic                        s_cache_hit,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [vtlf_pkg::KIND_W-1:0] m_type_out,
    output logic                        m_fill_mark_out,
    output logic                        m_victim_hit,
    output logic [vtlf_pkg::HIT_W-1:0]  m_hit_total
);

    // only cores addressable by the core id field own a list
    localparam int CORE_IDS = 2 ** vtlf_pkg::CORE_W;
    localparam int LISTS    = (CORE_COUNT < CORE_IDS) ? CORE_COUNT : CORE_IDS;
    localparam int LIST_W   = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int SLOT_W   = $clog2(LIST_ENTRIES);
    localparam int CNT_W    = $clog2(LIST_ENTRIES + 1);
    localparam int MEM_D    = LISTS * LIST_ENTRIES;
    localparam int MEM_AW   = $clog2(MEM_D);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    state_t state_reg;

    // per-list ring: fill level and physical slot of the oldest entry
    logic [CNT_W-1:0]  fill_reg [LISTS];
    logic [SLOT_W-1:0] head_reg [LISTS];

    // transaction in flight
    logic [vtlf_pkg::KIND_W-1:0] kind_reg;
    logic                        mark_reg;
    logic                        vhit_reg;
    logic [vtlf_pkg::ADDR_W-1:0] addr_reg;
    logic [LIST_W-1:0]           core_reg;
    logic [MEM_AW-1:0]           base_reg;
    logic [CNT_W-1:0]            n_reg;
    logic [SLOT_W-1:0]           hd_reg;
    logic [vtlf_pkg::HIT_W-1:0]  hit_cnt_reg;

    // scan pipeline
    logic [CNT_W-1:0]  k_reg;       // logical slots issued
    logic [SLOT_W-1:0] ph_rd_reg;   // physical slot of next read
    logic              dv_reg;      // ram read data holds a list slot
    logic [SLOT_W-1:0] dphys_reg;   // physical slot of that data
    logic [SLOT_W-1:0] prev_reg;    // physical slot of the previous data
    logic              shift_reg;   // hit seen, younger entries move one slot older

    // output register
    logic                        m_valid_reg;
    logic [vtlf_pkg::KIND_W-1:0] m_type_reg;
    logic                        m_mark_reg;
    logic                        m_vhit_reg;
    logic [vtlf_pkg::HIT_W-1:0]  m_hit_reg;

    logic                        s_accept;
    logic [LIST_W-1:0]           s_core_idx;
    logic                        s_core_ok;
    logic                        s_search;
    logic                        issue;
    logic                        match;
    logic [SLOT_W-1:0]           ph_rd_next;
    logic [SLOT_W-1:0]           hd_next;
    logic                        list_full;
    logic                        out_load;

    logic                        ram_rd_en;
    logic [MEM_AW-1:0]           ram_rd_addr;
    logic [vtlf_pkg::ADDR_W-1:0] ram_rd_data;
    logic                        ram_wr_en;
    logic [MEM_AW-1:0]           ram_wr_addr;
    logic [vtlf_pkg::ADDR_W-1:0] ram_wr_data;

    assign s_ready    = (state_reg == ST_IDLE);
    assign s_accept   = s_valid && s_ready;
    assign s_core_idx = s_core_id[LIST_W-1:0];
    assign s_core_ok  = (int'(s_core_id) < LISTS);

    // unmarked write or fill that missed the dram cache searches its list
    assign s_search = ((s_req_type == vtlf_pkg::KIND_FILL) ||
                       (s_req_type == vtlf_pkg::KIND_WRITE)) &&
                      !s_fill_mark_in && !s_cache_hit && s_core_ok;

    assign issue      = (state_reg == ST_SCAN) && (k_reg < n_reg);
    assign match      = dv_reg && (ram_rd_data == addr_reg);
    assign ph_rd_next = (ph_rd_reg == SLOT_W'(LIST_ENTRIES - 1)) ? '0 : ph_rd_reg + 1'b1;
    assign hd_next    = (hd_reg == SLOT_W'(LIST_ENTRIES - 1)) ? '0 : hd_reg + 1'b1;
    assign list_full  = (n_reg == CNT_W'(LIST_ENTRIES));

    // result moves into the output register once that register is free
    assign out_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // ram port control
    always_comb begin
        ram_rd_en   = issue;
        ram_rd_addr = base_reg + MEM_AW'(ph_rd_reg);
        ram_wr_en   = 1'b0;
        ram_wr_addr = base_reg + MEM_AW'(prev_reg);
        ram_wr_data = ram_rd_data;
        unique case (state_reg)
            ST_SCAN: begin
                // move a younger entry into the slot just vacated
                ram_wr_en = dv_reg && shift_reg;
            end
            ST_WRITE: begin
                // hit: address becomes newest at the last slot
                // miss: append at the tail, or over the oldest when full
                ram_wr_en   = 1'b1;
                ram_wr_data = addr_reg;
                if (!shift_reg) begin
                    ram_wr_addr = base_reg + MEM_AW'(ph_rd_reg);
                end
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    vtlf_tag_ram #(
        .DEPTH (MEM_D),
        .AW    (MEM_AW),
        .DW    (vtlf_pkg::ADDR_W)
    ) u_tag_ram (
        .aclk    (aclk),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            dv_reg      <= 1'b0;
            hit_cnt_reg <= '0;
            for (int i = 0; i < LISTS; i++) begin
                fill_reg[i] <= '0;
                head_reg[i] <= '0;
            end
        end else begin
            priority if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            dv_reg <= issue;

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        mark_reg  <= s_fill_mark_in;
                        vhit_reg  <= 1'b0;
                        addr_reg  <= s_phys_addr;
                        core_reg  <= s_core_idx;
                        priority if ((s_req_type == vtlf_pkg::KIND_FILL) &&
                                     s_fill_mark_in) begin
                            // marked fill goes on as a read
                            kind_reg  <= vtlf_pkg::KIND_READ;
                            state_reg <= ST_DONE;
                        end else if (s_search) begin
                            kind_reg  <= s_req_type;
                            base_reg  <= MEM_AW'(int'(s_core_idx) * LIST_ENTRIES);
                            n_reg     <= fill_reg[s_core_idx];
                            hd_reg    <= head_reg[s_core_idx];
                            ph_rd_reg <= head_reg[s_core_idx];
                            k_reg     <= '0;
                            shift_reg <= 1'b0;
                            state_reg <= ST_SCAN;
                        end else begin
                            kind_reg  <= s_req_type;
                            state_reg <= ST_DONE;
                        end
                    end
                end

                ST_SCAN: begin
                    if (issue) begin
                        k_reg     <= k_reg + 1'b1;
                        ph_rd_reg <= ph_rd_next;
                        dphys_reg <= ph_rd_reg;
                    end
                    if (dv_reg) begin
                        prev_reg <= dphys_reg;
                        if (match) begin
                            shift_reg <= 1'b1;
                        end
                    end
                    if (!issue && !dv_reg) begin
                        state_reg <= ST_WRITE;
                    end
                end

                ST_WRITE: begin
                    if (shift_reg) begin
                        vhit_reg    <= 1'b1;
                        mark_reg    <= 1'b1;
                        hit_cnt_reg <= hit_cnt_reg + 1'b1;
                        if (kind_reg == vtlf_pkg::KIND_FILL) begin
                            kind_reg <= vtlf_pkg::KIND_READ;
                        end
                    end else if (list_full) begin
                        // oldest entry overwritten, ring start advances
                        head_reg[core_reg] <= hd_next;
                    end else begin
                        fill_reg[core_reg] <= n_reg + 1'b1;
                    end
                    state_reg <= ST_DONE;
                end

                ST_DONE: begin
                    if (out_load) begin
                        m_type_reg  <= kind_reg;
                        m_mark_reg  <= mark_reg;
                        m_vhit_reg  <= vhit_reg;
                        m_hit_reg   <= hit_cnt_reg;
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_type_out      = m_type_reg;
    assign m_fill_mark_out = m_mark_reg;
    assign m_victim_hit    = m_vhit_reg;
    assign m_hit_total     = m_hit_reg;

`ifndef SYNTHESIS
    // a victim hit always sets the fill mark and never leaves a fill kind
    a_hit_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_victim_hit) |->
            (m_fill_mark_out && (m_type_out != vtlf_pkg::KIND_FILL)))
        else $error("victim hit without fill mark or with fill kind");

    // the hit counter steps by one on each write-back of a hit
    a_hit_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE && shift_reg) |=> (hit_cnt_reg == $past(hit_cnt_reg) + 1'b1))
        else $error("hit counter not incremented on hit");

    // the scan never issues past the fill level
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (k_reg <= n_reg))
        else $error("scan index beyond fill level");

    // read data is only tracked while scanning
    a_dv_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        dv_reg |-> (state_reg == ST_SCAN))
        else $error("ram data valid outside scan");
`endif

endmodule
